[hdl/matrix_multiply_engine_top_defines.svh]
// Assertion macros for the matrix multiply engine
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define MME_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mme assertion failed");

// next-cycle implication
`define MME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mme assertion failed");

`endif

[hdl/mme_pkg.sv]
`default_nettype none
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CFG_W       = 4;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + DIM_W;
    localparam int FRAC_W      = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_COLS   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WAIT,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic shift;
        logic mul;
        logic acc_en;
        logic acc_first;
    } cell_ctrl_t;

    typedef struct packed {
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic [DIM_W-1:0]  out_sel;
        logic [ADDR_W-1:0] out_index;
        logic              out_last;
        logic              out_load;
    } seq_out_t;

    // dimension register to (clamped dimension - 1)
    function automatic logic [DIM_W-1:0] dim_m1(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = '0;
        end else if (d > CFG_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM - 1);
        end else begin
            r = DIM_W'(d - 1'b1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/mme_cell.sv]
`default_nettype none
module mme_cell (
    input  wire                                 aclk,
    input  mme_pkg::cell_ctrl_t                 ctrl,
    input  wire signed [mme_pkg::DATA_W-1:0]    a_value,
    input  wire signed [mme_pkg::DATA_W-1:0]    b_in,
    output logic signed [mme_pkg::DATA_W-1:0]   b_out,
    output logic signed [mme_pkg::ACC_W-1:0]    acc
);

    logic signed [mme_pkg::DATA_W-1:0] b_reg;
    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic signed [mme_pkg::ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            b_reg <= b_in;
        end
        if (ctrl.mul) begin
            prod_reg <= a_value * b_reg;
        end
        if (ctrl.acc_en) begin
            if (ctrl.acc_first) begin
                acc_reg <= mme_pkg::ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + mme_pkg::ACC_W'(prod_reg);
            end
        end
    end

    assign b_out = b_reg;
    assign acc   = acc_reg;

endmodule
`default_nettype wire

[hdl/mme_seq.sv]
`default_nettype none
module mme_seq (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire                          out_free,
    input  wire [mme_pkg::DIM_W-1:0]     rows_m1,
    input  wire [mme_pkg::DIM_W-1:0]     inner_m1,
    input  wire [mme_pkg::DIM_W-1:0]     cols_m1,
    output logic                         idle,
    output mme_pkg::cell_ctrl_t          cell_ctrl,
    output mme_pkg::seq_out_t            seq_out
);

    localparam int MW = 2 * mme_pkg::DIM_W + 1;

    mme_pkg::seq_state_t state_reg, state_next;
    logic [mme_pkg::DIM_W-1:0] i_reg, i_next;
    logic [mme_pkg::DIM_W-1:0] k_reg, k_next;
    logic [mme_pkg::DIM_W-1:0] j_reg, j_next;
    logic                      shift_reg, shift_next;
    logic [mme_pkg::DIM_W:0]   inner_n, cols_n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mme_pkg::ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            shift_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            shift_reg <= shift_next;
        end
    end

    assign inner_n = {1'b0, inner_m1} + 1'b1;
    assign cols_n  = {1'b0, cols_m1} + 1'b1;

    always_comb begin
        state_next          = state_reg;
        i_next              = i_reg;
        k_next              = k_reg;
        j_next              = j_reg;
        shift_next          = (state_reg == mme_pkg::ST_FILL);
        idle                = 1'b0;
        cell_ctrl.shift     = shift_reg;
        cell_ctrl.mul       = 1'b0;
        cell_ctrl.acc_en    = 1'b0;
        cell_ctrl.acc_first = (k_reg == '0);
        seq_out.out_load    = 1'b0;
        case (state_reg)
            mme_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    i_next     = '0;
                    k_next     = '0;
                    j_next     = cols_m1;
                    state_next = mme_pkg::ST_FILL;
                end
            end
            mme_pkg::ST_FILL: begin
                if (j_reg == '0) begin
                    state_next = mme_pkg::ST_WAIT;
                end else begin
                    j_next = j_reg - 1'b1;
                end
            end
            mme_pkg::ST_WAIT: begin
                state_next = mme_pkg::ST_MUL;
            end
            mme_pkg::ST_MUL: begin
                cell_ctrl.mul = 1'b1;
                state_next    = mme_pkg::ST_ACC;
            end
            mme_pkg::ST_ACC: begin
                cell_ctrl.acc_en = 1'b1;
                if (k_reg == inner_m1) begin
                    j_next     = '0;
                    state_next = mme_pkg::ST_OUT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    j_next     = cols_m1;
                    state_next = mme_pkg::ST_FILL;
                end
            end
            mme_pkg::ST_OUT: begin
                if (out_free) begin
                    seq_out.out_load = 1'b1;
                    if (j_reg == cols_m1) begin
                        if (i_reg == rows_m1) begin
                            state_next = mme_pkg::ST_IDLE;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            k_next     = '0;
                            j_next     = cols_m1;
                            state_next = mme_pkg::ST_FILL;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    assign seq_out.a_addr    = mme_pkg::ADDR_W'(MW'(i_reg) * MW'(inner_n) + MW'(k_reg));
    assign seq_out.b_addr    = mme_pkg::ADDR_W'(MW'(k_reg) * MW'(cols_n) + MW'(j_reg));
    assign seq_out.out_index = mme_pkg::ADDR_W'(MW'(i_reg) * MW'(cols_n) + MW'(j_reg));
    assign seq_out.out_sel   = j_reg;
    assign seq_out.out_last  = (i_reg == rows_m1) && (j_reg == cols_m1);

endmodule
`default_nettype wire

[hdl/matrix_multiply_engine_top.sv]
// Loads: one word per cycle while idle, no result.
// Compute: per product row, the cell chain runs fill, wait, multiply and
// accumulate once per inner index, then emits the row one word at a time as
// the output frees. Rate is set by the single B read port.
// Reset: control, output valid and dimensions (8 each) clear; stores keep contents.
`default_nettype none
module matrix_multiply_engine_top (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // operation[1:0], element_index[7:2], element_value[39:8]
    input  wire [mme_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // product_value[31:0], product_index[37:32], zero[39:38]
    output logic [mme_pkg::M_TDATA_W-1:0]    m_tdata,
    // saturated
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  wire                              cfg_wr_en,
    input  wire [1:0]                        cfg_index,
    input  wire [mme_pkg::CFG_W-1:0]         cfg_data
);

    logic [mme_pkg::CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [mme_pkg::DATA_W-1:0] mem_a [mme_pkg::DEPTH];
    logic [mme_pkg::DATA_W-1:0] mem_b [mme_pkg::DEPTH];
    logic signed [mme_pkg::DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic                        accept, idle, out_free;
    logic [1:0]                  in_op;
    logic [mme_pkg::ADDR_W-1:0]  in_idx;
    logic [mme_pkg::DATA_W-1:0]  in_val;
    mme_pkg::cell_ctrl_t         cell_ctrl;
    mme_pkg::seq_out_t           seq_out;

    logic signed [mme_pkg::DATA_W-1:0] b_chain [mme_pkg::MAX_DIM+1];
    logic signed [mme_pkg::ACC_W-1:0]  acc_w   [mme_pkg::MAX_DIM];
    logic signed [mme_pkg::ACC_W-1:0]  acc_sel;
    logic signed [mme_pkg::ACC_W-mme_pkg::FRAC_W-1:0] shifted;
    logic                        fits;
    logic [mme_pkg::DATA_W-1:0]  sat_val;

    logic                        m_valid_reg;
    logic [mme_pkg::DATA_W-1:0]  m_value_reg;
    logic [mme_pkg::ADDR_W-1:0]  m_index_reg;
    logic                        m_sat_reg, m_last_reg;

    assign in_op    = s_tdata[1:0];
    assign in_idx   = s_tdata[7:2];
    assign in_val   = s_tdata[39:8];
    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= mme_pkg::CFG_W'(mme_pkg::MAX_DIM);
            inner_reg <= mme_pkg::CFG_W'(mme_pkg::MAX_DIM);
            cols_reg  <= mme_pkg::CFG_W'(mme_pkg::MAX_DIM);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mme_pkg::REG_ROWS:  rows_reg  <= cfg_data;
                mme_pkg::REG_INNER: inner_reg <= cfg_data;
                mme_pkg::REG_COLS:  cols_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_op == mme_pkg::OP_LOAD_A) begin
            mem_a[in_idx] <= in_val;
        end
        if (accept && in_op == mme_pkg::OP_LOAD_B) begin
            mem_b[in_idx] <= in_val;
        end
        rd_a_reg <= mem_a[seq_out.a_addr];
        rd_b_reg <= mem_b[seq_out.b_addr];
    end

    mme_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && in_op == mme_pkg::OP_COMPUTE),
        .out_free  (out_free),
        .rows_m1   (mme_pkg::dim_m1(rows_reg)),
        .inner_m1  (mme_pkg::dim_m1(inner_reg)),
        .cols_m1   (mme_pkg::dim_m1(cols_reg)),
        .idle      (idle),
        .cell_ctrl (cell_ctrl),
        .seq_out   (seq_out)
    );

    assign b_chain[0] = rd_b_reg;

    for (genvar c = 0; c < mme_pkg::MAX_DIM; c++) begin : g_cell
        mme_cell u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .a_value (rd_a_reg),
            .b_in    (b_chain[c]),
            .b_out   (b_chain[c+1]),
            .acc     (acc_w[c])
        );
    end

    assign acc_sel = acc_w[seq_out.out_sel];
    assign shifted = acc_sel[mme_pkg::ACC_W-1:mme_pkg::FRAC_W];
    assign fits    = (shifted[mme_pkg::ACC_W-mme_pkg::FRAC_W-1:mme_pkg::DATA_W-1] == '0) ||
                     (shifted[mme_pkg::ACC_W-mme_pkg::FRAC_W-1:mme_pkg::DATA_W-1] == '1);
    assign sat_val = acc_sel[mme_pkg::ACC_W-1] ? {1'b1, {(mme_pkg::DATA_W-1){1'b0}}}
                                               : {1'b0, {(mme_pkg::DATA_W-1){1'b1}}};
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_out.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_out.out_load) begin
            m_value_reg <= fits ? shifted[mme_pkg::DATA_W-1:0] : sat_val;
            m_sat_reg   <= !fits;
            m_index_reg <= seq_out.out_index;
            m_last_reg  <= seq_out.out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_index_reg, m_value_reg};
    assign m_tuser  = m_sat_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

[hdl/mme_checker.sv]
`default_nettype none
`include "matrix_multiply_engine_top_defines.svh"
module mme_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [mme_pkg::S_TDATA_W-1:0]    s_tdata,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [mme_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire                             m_tuser
);

    `MME_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    `MME_ASSERT_NOW(a_sat_bound, aclk, aresetn, m_tvalid && m_tuser,
        m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000)

    `MME_ASSERT_NEXT(a_busy_after_compute, aclk, aresetn,
        s_tvalid && s_tready && s_tdata[1:0] == mme_pkg::OP_COMPUTE, !s_tready)

    `MME_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[39:38] == 2'b00)

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  index;
        logic        sat;
        logic        last;
    } product_t;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  idx;
        logic [31:0] val;
        bit          typed;
        logic [31:0] exp_value;
        logic        exp_sat;
    } drow_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [mme_pkg::S_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [mme_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [mme_pkg::CFG_W-1:0] cfg_data;

    matrix_multiply_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [31:0] left_store [mme_pkg::DEPTH];
    logic [31:0] right_store [mme_pkg::DEPTH];
    bit left_written [mme_pkg::DEPTH];
    bit right_written [mme_pkg::DEPTH];
    logic [mme_pkg::CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    product_t product_q[$];
    int errors;
    int words_loaded;
    int snd_idle_pct;
    int rcv_idle_pct;
    int idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int clamp_dim(input logic [mme_pkg::CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > mme_pkg::MAX_DIM) return mme_pkg::MAX_DIM;
        return int'(d);
    endfunction

    function automatic void predict_product();
        int rows, inner, cols;
        logic signed [71:0] acc;
        logic signed [71:0] sh;
        longint p;
        product_t e;
        rows  = clamp_dim(rows_reg);
        inner = clamp_dim(inner_reg);
        cols  = clamp_dim(cols_reg);
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                acc = '0;
                for (int k = 0; k < inner; k++) begin
                    p = longint'($signed(left_store[(i * inner + k) % mme_pkg::DEPTH])) *
                        longint'($signed(right_store[(k * cols + j) % mme_pkg::DEPTH]));
                    acc = acc + 72'(p);
                end
                sh = acc >>> mme_pkg::FRAC_W;
                e.sat = 1'b1;
                if (sh > 72'sd2147483647) begin
                    e.value = 32'h7FFF_FFFF;
                end else if (sh < -72'sd2147483648) begin
                    e.value = 32'h8000_0000;
                end else begin
                    e.value = sh[31:0];
                    e.sat = 1'b0;
                end
                e.index = 6'(i * cols + j);
                e.last = (i == rows - 1) && (j == cols - 1);
                product_q.push_back(e);
            end
        end
    endfunction

    function automatic void apply_word(input logic [1:0] op, input logic [5:0] idx,
                                       input logic [31:0] val);
        case (op)
            mme_pkg::OP_LOAD_A: begin
                left_store[idx] = val;
                left_written[idx] = 1;
                words_loaded++;
            end
            mme_pkg::OP_LOAD_B: begin
                right_store[idx] = val;
                right_written[idx] = 1;
                words_loaded++;
            end
            mme_pkg::OP_COMPUTE: begin
                predict_product();
                words_loaded++;
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [5:0] idx,
                             input logic [31:0] val);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata = mme_pkg::S_TDATA_W'({$urandom(), $urandom()});
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {val, idx, op};
        do @(posedge aclk); while (!s_tready);
        apply_word(op, idx, val);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (product_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [mme_pkg::CFG_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            mme_pkg::REG_ROWS:  rows_reg = val;
            mme_pkg::REG_INNER: inner_reg = val;
            mme_pkg::REG_COLS:  cols_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_dims(input logic [mme_pkg::CFG_W-1:0] r,
                            input logic [mme_pkg::CFG_W-1:0] n,
                            input logic [mme_pkg::CFG_W-1:0] c);
        wait_idle();
        write_reg(mme_pkg::REG_ROWS, r);
        write_reg(mme_pkg::REG_INNER, n);
        write_reg(mme_pkg::REG_COLS, c);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed(-$urandom_range(0, 32'h0003_FFFF)));
            default: return $urandom_range(0, 32'h0003_FFFF);
        endcase
    endfunction

    function automatic logic [mme_pkg::CFG_W-1:0] rand_dim();
        case ($urandom_range(0, 19))
            0: return 4'd0;
            1: return 4'd15;
            2, 3: return 4'd8;
            default: return mme_pkg::CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // every entry the product walks is loaded first
    task automatic run_compute();
        int rows, inner, cols;
        rows  = clamp_dim(rows_reg);
        inner = clamp_dim(inner_reg);
        cols  = clamp_dim(cols_reg);
        for (int i = 0; i < rows * inner; i++)
            if (!left_written[i]) send_word(mme_pkg::OP_LOAD_A, 6'(i), rand_value());
        for (int i = 0; i < inner * cols; i++)
            if (!right_written[i]) send_word(mme_pkg::OP_LOAD_B, 6'(i), rand_value());
        send_word(mme_pkg::OP_COMPUTE, 6'($urandom()), $urandom());
    endtask

    task automatic random_batch();
        int span, nloads;
        set_dims(rand_dim(), rand_dim(), rand_dim());
        span = clamp_dim(rows_reg) * clamp_dim(inner_reg);
        if (clamp_dim(inner_reg) * clamp_dim(cols_reg) > span)
            span = clamp_dim(inner_reg) * clamp_dim(cols_reg);
        nloads = $urandom_range(0, 12);
        for (int n = 0; n < nloads; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(OP_UNUSED, 6'($urandom()), $urandom());
            else if ($urandom_range(0, 7) == 0)
                send_word(2'($urandom_range(0, 1)), 6'($urandom()), rand_value());
            else
                send_word(2'($urandom_range(0, 1)), 6'($urandom_range(0, span - 1)),
                          rand_value());
        end
        run_compute();
    endtask

    task automatic report(input string what, input logic [39:0] e, input logic [39:0] a);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %h actual %h", what, e, a);
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge aclk) begin
        product_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (product_q.size() == 0) begin
                report("unexpected word", '0, m_tdata);
            end else begin
                e = product_q.pop_front();
                if (m_tdata[31:0] !== e.value)
                    report("value", 40'(e.value), 40'(m_tdata[31:0]));
                if (m_tdata[37:32] !== e.index)
                    report("index", 40'(e.index), 40'(m_tdata[37:32]));
                if (m_tuser !== e.sat) report("saturated", 40'(e.sat), 40'(m_tuser));
                if (m_tlast !== e.last) report("last", 40'(e.last), 40'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    drow_t directed [] = '{
        '{mme_pkg::OP_LOAD_A,  6'd0,  32'h7FFF_FFFF, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_LOAD_B,  6'd0,  32'h7FFF_FFFF, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_COMPUTE, 6'd0,  32'h0,         1, 32'h7FFF_FFFF, 1'b1},
        '{mme_pkg::OP_LOAD_A,  6'd0,  32'h8000_0000, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_COMPUTE, 6'd63, 32'hFFFF_FFFF, 1, 32'h8000_0000, 1'b1},
        '{mme_pkg::OP_LOAD_B,  6'd0,  32'h8000_0000, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_COMPUTE, 6'd0,  32'h0,         1, 32'h7FFF_FFFF, 1'b1},
        '{mme_pkg::OP_LOAD_A,  6'd0,  32'h0001_0000, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_LOAD_B,  6'd0,  32'hFFFF_0000, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_COMPUTE, 6'd0,  32'h0,         1, 32'hFFFF_0000, 1'b0},
        '{mme_pkg::OP_LOAD_A,  6'd0,  32'h0000_0001, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_LOAD_B,  6'd0,  32'hFFFF_FFFF, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_COMPUTE, 6'd0,  32'h0,         1, 32'hFFFF_FFFF, 1'b0},
        '{OP_UNUSED,           6'd63, 32'hFFFF_FFFF, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_LOAD_A,  6'd63, 32'h1234_5678, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_LOAD_B,  6'd63, 32'hFFFF_FFFF, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_LOAD_A,  6'd0,  32'h0000_0000, 0, 32'h0, 1'b0},
        '{mme_pkg::OP_COMPUTE, 6'd0,  32'h0,         1, 32'h0000_0000, 1'b0}
    };

    initial begin
        errors = 0;
        words_loaded = 0;
        snd_idle_pct = 38;
        rcv_idle_pct = 63;
        rows_reg = 4'd8;
        inner_reg = 4'd8;
        cols_reg = 4'd8;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // zero dimensions act as 1x1x1
        set_dims(4'd0, 4'd0, 4'd0);
        foreach (directed[n]) begin
            send_word(directed[n].op, directed[n].idx, directed[n].val);
            if (directed[n].typed && (product_q.size() == 0 ||
                product_q[$].value !== directed[n].exp_value ||
                product_q[$].sat !== directed[n].exp_sat))
                report("typed row", 40'({directed[n].exp_sat, directed[n].exp_value}),
                       40'({product_q[$].sat, product_q[$].value}));
        end
        s_tvalid = 1'b0;

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 63 : 0;
            rcv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 38 : 0;
            if (ph == 1) begin
                set_dims(4'd8, 4'd8, 4'd8);
                run_compute();
            end else if (ph == 2) begin
                set_dims(4'd15, 4'd1, 4'd15);
                run_compute();
            end
            while (words_loaded < 105 * (ph + 1) + directed.size())
                random_batch();
            s_tvalid = 1'b0;
        end

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
